// ===== hw/rtl/olb_pkg.sv =====
package olb_pkg;

	// request codes
	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_POP    = 3'd1,
		REQ_INSERT = 3'd2,
		REQ_ERASE  = 3'd3,
		REQ_READ   = 3'd4
	} olb_req_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} olb_status_t;

	typedef struct packed {
		olb_req_t    req_type;
		logic [4:0]  position;
		logic [31:0] element_value;
	} olb_in_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [4:0]  item_count;
		olb_status_t status;
	} olb_out_t;

	// broadcast command to the cell row
	typedef struct packed {
		logic ins_en;
		logic ers_en;
	} olb_cmd_t;

endpackage

// ===== hw/rtl/olb_cell.sv =====
module olb_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int TGT_W      = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  olb_pkg::olb_cmd_t     cmd,
	input  logic [TGT_W-1:0]      tgt,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] sel_data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  hit;
	logic                  above;

	assign hit   = (tgt == TGT_W'(INDEX));
	assign above = (tgt < TGT_W'(INDEX));

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (hit) begin
				data_q <= value;
			end else if (above) begin
				data_q <= left_data;
			end
		end else if (cmd.ers_en) begin
			if (hit || above) begin
				data_q <= right_data;
			end
		end
	end

	assign data     = data_q;
	// only the addressed cell drives the read bus
	assign sel_data = hit ? data_q : '0;

endmodule

// ===== hw/rtl/ordered_list_buffer.sv =====
// Ordered list of up to DEPTH elements with a running count. Each request
// transaction appends, removes the last element, inserts at a position
// (later elements move up one slot), erases at a position (later elements
// move down one slot) or reads an element, and produces exactly one response
// transaction with the read data, the count after the request and a status.
// The list lives in a row of DEPTH cells that all shift in the same clock,
// so a request can be accepted every cycle while the response side keeps
// draining; the response is captured in the output register at the accepting
// edge and is offered from the next cycle. A response held by a low rsp_ready
// holds off the next request. The read path is a one-hot select across the
// cell row. Requests that cannot be carried out (full, empty, position out of
// range) leave the list untouched and report an error status.
module ordered_list_buffer #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  olb_pkg::olb_in_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output olb_pkg::olb_out_t rsp
);

	// count width, able to hold DEPTH itself
	localparam int CW = $clog2(DEPTH + 1);
	// common width for comparing position against the count
	localparam int PW = (CW > 5) ? CW : 5;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         tgt;
	logic                  req_accept;
	logic                  full;
	logic                  rd_ok;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         cnt_w;
	olb_pkg::olb_cmd_t     cmd;
	olb_pkg::olb_cmd_t     cmd_g;
	olb_pkg::olb_status_t  st;
	logic [DATA_WIDTH-1:0] wr_value;
	logic [DATA_WIDTH-1:0] rd_or;
	logic                  out_valid_q;
	olb_pkg::olb_out_t     out_q;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_sel  [DEPTH];
	logic [DATA_WIDTH-1:0] left_d    [DEPTH];
	logic [DATA_WIDTH-1:0] right_d   [DEPTH];

	// output register frees the request side whenever it drains
	assign req_ready  = !out_valid_q || rsp_ready;
	assign req_accept = req_valid && req_ready;

	assign full     = (count_q == CW'(DEPTH));
	assign pos_w    = PW'(req.position);
	assign cnt_w    = PW'(count_q);
	assign wr_value = DATA_WIDTH'(req.element_value);

	// request decode: which way the cells move and the new count
	always_comb begin
		cmd     = '0;
		count_d = count_q;
		st      = olb_pkg::ST_OK;
		rd_ok   = 1'b0;
		tgt     = CW'(req.position);
		unique case (req.req_type)
			olb_pkg::REQ_APPEND: begin
				if (full) begin
					st = olb_pkg::ST_FULL;
				end else begin
					// append is an insert at the tail
					cmd.ins_en = 1'b1;
					tgt        = count_q;
					count_d    = CW'(count_q + 1'b1);
				end
			end
			olb_pkg::REQ_POP: begin
				if (count_q == '0) begin
					st = olb_pkg::ST_RANGE;
				end else begin
					count_d = CW'(count_q - 1'b1);
				end
			end
			olb_pkg::REQ_INSERT: begin
				// fullness wins over a bad position
				if (full) begin
					st = olb_pkg::ST_FULL;
				end else if (pos_w > cnt_w) begin
					st = olb_pkg::ST_RANGE;
				end else begin
					cmd.ins_en = 1'b1;
					count_d    = CW'(count_q + 1'b1);
				end
			end
			olb_pkg::REQ_ERASE: begin
				if (pos_w >= cnt_w) begin
					st = olb_pkg::ST_RANGE;
				end else begin
					cmd.ers_en = 1'b1;
					count_d    = CW'(count_q - 1'b1);
				end
			end
			olb_pkg::REQ_READ: begin
				if (pos_w >= cnt_w) begin
					st = olb_pkg::ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
				// unknown request codes are ignored and report ok
			end
		endcase
	end

	// cells only move on an accepted transaction
	assign cmd_g = req_accept ? cmd : '0;

	// neighbour links along the row; the ends read as zero, and only the right end is ever selected (on an erase)
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			left_d[i]  = (i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1];
			right_d[i] = (i == DEPTH - 1) ? '0 : cell_data[(i == DEPTH - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		olb_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.TGT_W     (CW),
			.INDEX     (g)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd_g),
			.tgt       (tgt),
			.value     (wr_value),
			.left_data (left_d[g]),
			.right_data(right_d[g]),
			.data      (cell_data[g]),
			.sel_data  (cell_sel[g])
		);
	end

	// read bus: at most one cell drives a non-zero word
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_sel[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset needed
	always_ff @(posedge clk) begin
		if (req_accept) begin
			out_q.read_value <= rd_ok ? 32'(rd_or) : '0;
			out_q.item_count <= 5'(count_d);
			out_q.status     <= st;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== hw/rtl/ordered_list_buffer_chk.sv =====
module ordered_list_buffer_chk #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input olb_pkg::olb_in_t  req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input olb_pkg::olb_out_t rsp
);

	// every accepted request yields a response in the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("response missing after accepted request");

	// failed requests never carry read data
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != olb_pkg::ST_OK |-> rsp.read_value == '0)
		else $error("error response with read data");

	// full status only with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == olb_pkg::ST_FULL |-> rsp.item_count == 5'(DEPTH))
		else $error("full status with list not full");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// no response without a request while idle on the input side
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
		else $error("response without a request");

endmodule

bind ordered_list_buffer ordered_list_buffer_chk #(
	.DEPTH     (DEPTH),
	.DATA_WIDTH(DATA_WIDTH)
) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;

	localparam int LIST_DEPTH    = 16;
	localparam int ELEM_WIDTH    = 32;
	localparam int POS_MAX       = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	// request codes outside the defined set, which the block must ignore
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	olb_pkg::olb_in_t  req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	olb_pkg::olb_out_t rsp;

	ordered_list_buffer #(
		.DEPTH(LIST_DEPTH),
		.DATA_WIDTH(ELEM_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// 20 time unit period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the list, updated when a request transaction is accepted
	logic [ELEM_WIDTH-1:0] list_slots [LIST_DEPTH];
	int                    list_count = 0;
	olb_pkg::olb_out_t     expected_results [$];

	// run statistics
	int          req_counts [8];
	int          full_rejects  = 0;
	int          range_rejects = 0;
	int          peak_count    = 0;
	int          compared      = 0;
	int          mismatches    = 0;
	int          burst_left    = 0;
	int unsigned cycle_count   = 0;

	// apply one request to the shadow list and return the response it should give
	function automatic olb_pkg::olb_out_t apply_list_request(input olb_pkg::olb_in_t r);
		olb_pkg::olb_out_t res;
		int                i;
		res.read_value = '0;
		res.status     = olb_pkg::ST_OK;
		case (r.req_type)
			olb_pkg::REQ_APPEND: begin
				if (list_count >= LIST_DEPTH) begin
					res.status = olb_pkg::ST_FULL;
				end else begin
					list_slots[list_count] = r.element_value;
					list_count++;
				end
			end
			olb_pkg::REQ_POP: begin
				if (list_count == 0) begin
					res.status = olb_pkg::ST_RANGE;
				end else begin
					list_count--;
				end
			end
			olb_pkg::REQ_INSERT: begin
				// fullness wins over a bad position
				if (list_count >= LIST_DEPTH) begin
					res.status = olb_pkg::ST_FULL;
				end else if (int'(r.position) > list_count) begin
					res.status = olb_pkg::ST_RANGE;
				end else begin
					for (i = list_count; i > int'(r.position); i--)
						list_slots[i] = list_slots[i-1];
					list_slots[r.position] = r.element_value;
					list_count++;
				end
			end
			olb_pkg::REQ_ERASE: begin
				if (int'(r.position) >= list_count) begin
					res.status = olb_pkg::ST_RANGE;
				end else begin
					for (i = int'(r.position); i + 1 < list_count; i++)
						list_slots[i] = list_slots[i+1];
					list_count--;
				end
			end
			olb_pkg::REQ_READ: begin
				if (int'(r.position) >= list_count)
					res.status = olb_pkg::ST_RANGE;
				else
					res.read_value = list_slots[r.position];
			end
			default: begin
				// unused codes leave everything as it was
			end
		endcase
		res.item_count = 5'(list_count);
		return res;
	endfunction

	function automatic olb_pkg::olb_in_t make_req(input olb_pkg::olb_req_t kind, input int pos,
			input logic [31:0] val);
		olb_pkg::olb_in_t r;
		r.req_type      = kind;
		r.position      = 5'(pos);
		r.element_value = val;
		return r;
	endfunction

	// element values lean towards all-zero and all-one words
	function automatic logic [31:0] pick_element();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// mostly a legal index up to top, now and then any index up to POS_MAX
	function automatic int pick_position(input int top);
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(0, POS_MAX);
		return $urandom_range(0, top);
	endfunction

	// drive one request transaction, predict its response once accepted, then
	// sometimes idle if the current burst has run out
	task automatic send_item(input olb_pkg::olb_in_t item);
		olb_pkg::olb_out_t want;
		int                gap;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		want = apply_list_request(item);
		expected_results.insert(expected_results.size(), want);
		req_counts[item.req_type]++;
		if (want.status == olb_pkg::ST_FULL)
			full_rejects++;
		if (want.status == olb_pkg::ST_RANGE)
			range_rejects++;
		if (list_count > peak_count)
			peak_count = list_count;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// a third of the bursts run straight into the next one
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// hold the sender off until every outstanding response has come back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// every error path on an empty list, plus the lowest and highest unused request codes
	task automatic test_empty_list();
		send_item(make_req(olb_pkg::REQ_POP, 0, '0));
		send_item(make_req(olb_pkg::REQ_ERASE, 0, '0));
		send_item(make_req(olb_pkg::REQ_READ, POS_MAX, '0));
		send_item(make_req(olb_pkg::REQ_INSERT, 1, 32'h1234_5678));
		send_item(make_req(olb_pkg::olb_req_t'(REQ_UNUSED_LO), POS_MAX, '1));
		send_item(make_req(olb_pkg::olb_req_t'(REQ_UNUSED_HI), 0, '1));
	endtask

	// fill to capacity, hit the full checks, then shift at both ends
	task automatic test_fill_and_full();
		int k;
		send_item(make_req(olb_pkg::REQ_INSERT, 0, '1));
		for (k = 1; k < LIST_DEPTH; k++) begin
			case (k % 4)
				0: send_item(make_req(olb_pkg::REQ_APPEND, 0, '0));
				1: send_item(make_req(olb_pkg::REQ_APPEND, POS_MAX, 32'hAAAA_AAAA));
				2: send_item(make_req(olb_pkg::REQ_APPEND, 0, 32'h5555_5555));
				default: send_item(make_req(olb_pkg::REQ_APPEND, 0, $urandom()));
			endcase
		end
		send_item(make_req(olb_pkg::REQ_APPEND, 0, 32'hDEAD_BEEF));
		send_item(make_req(olb_pkg::REQ_INSERT, POS_MAX, 32'hDEAD_BEEF));
		send_item(make_req(olb_pkg::REQ_READ, LIST_DEPTH - 1, '0));
		send_item(make_req(olb_pkg::REQ_ERASE, 0, '0));
		// insert at the count lands at the end
		send_item(make_req(olb_pkg::REQ_INSERT, LIST_DEPTH - 1, 32'h8000_0001));
		send_item(make_req(olb_pkg::REQ_ERASE, LIST_DEPTH - 1, '0));
	endtask

	// random traffic that swings between filling and draining the list so
	// that both the full and the empty boundaries are hit again and again
	task automatic test_random_traffic(input int n_items);
		int                done;
		int                pick;
		bit                growing;
		int                last_idx;
		olb_pkg::olb_req_t kind;
		done    = 0;
		growing = 1'b1;
		while (done < n_items) begin
			if (list_count == LIST_DEPTH && $urandom_range(0, 2) == 0)
				growing = 1'b0;
			if (list_count == 0 && $urandom_range(0, 2) == 0)
				growing = 1'b1;
			last_idx = (list_count == 0) ? 0 : list_count - 1;
			pick     = $urandom_range(0, 99);
			if (pick < 2) begin
				// stray unused code, not counted as real traffic
				send_item(make_req(olb_pkg::olb_req_t'(3'($urandom_range(REQ_UNUSED_LO,
					REQ_UNUSED_HI))), $urandom_range(0, POS_MAX), $urandom()));
			end else begin
				if (growing)
					kind = (pick < 32) ? olb_pkg::REQ_APPEND :
						(pick < 60) ? olb_pkg::REQ_INSERT :
						(pick < 78) ? olb_pkg::REQ_READ :
						(pick < 89) ? olb_pkg::REQ_ERASE : olb_pkg::REQ_POP;
				else
					kind = (pick < 10) ? olb_pkg::REQ_APPEND :
						(pick < 20) ? olb_pkg::REQ_INSERT :
						(pick < 40) ? olb_pkg::REQ_READ :
						(pick < 70) ? olb_pkg::REQ_ERASE : olb_pkg::REQ_POP;
				case (kind)
					olb_pkg::REQ_INSERT: send_item(make_req(kind,
						pick_position(list_count), pick_element()));
					olb_pkg::REQ_ERASE, olb_pkg::REQ_READ: send_item(make_req(kind,
						pick_position(last_idx), pick_element()));
					default: send_item(make_req(kind, $urandom_range(0, POS_MAX),
						pick_element()));
				endcase
				done++;
			end
		end
	endtask

	// response checker: every accepted response is matched against the oldest
	// prediction, field by field
	always @(posedge clk) begin : check_response
		olb_pkg::olb_out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: response with nothing outstanding, got data %h count %0d status %0d",
					$time, rsp.read_value, rsp.item_count, rsp.status);
			end else begin
				want = expected_results.pop_front();
				compared++;
				if (rsp.read_value !== want.read_value) begin
					mismatches++;
					$display("%0t: read_value expected %h actual %h",
						$time, want.read_value, rsp.read_value);
				end
				if (rsp.item_count !== want.item_count) begin
					mismatches++;
					$display("%0t: item_count expected %0d actual %0d",
						$time, want.item_count, rsp.item_count);
				end
				if (rsp.status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
				end
			end
		end
	end

	// receiver back-pressure: the pattern follows bits 8:6 of the cycle counter, between
	// always ready, coin-toss stalls, a fixed one-in-four slot and long stalls
	always @(posedge clk) begin
		case (cycle_count[8:6])
			3'd2, 3'd5: rsp_ready <= $urandom_range(0, 1);
			3'd3:       rsp_ready <= (cycle_count[1:0] == 2'd0);
			3'd6:       rsp_ready <= ($urandom_range(0, 3) == 0);
			default:    rsp_ready <= 1'b1;
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		foreach (list_slots[i])
			list_slots[i] = '0;
		foreach (req_counts[i])
			req_counts[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_and_full();
		wait_for_results();
		test_random_traffic(220);
		// sender stands back until the block has answered everything
		wait_for_results();
		test_random_traffic(230);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d appends, %0d pops, %0d inserts, %0d erases, %0d reads",
			req_counts[olb_pkg::REQ_APPEND], req_counts[olb_pkg::REQ_POP],
			req_counts[olb_pkg::REQ_INSERT], req_counts[olb_pkg::REQ_ERASE],
			req_counts[olb_pkg::REQ_READ]);
		$display("%0d unused codes, %0d responses compared, %0d full, %0d range, peak %0d",
			req_counts[5] + req_counts[6] + req_counts[7], compared, full_rejects,
			range_rejects, peak_count);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
